// ===== hw/rtl/tun_pkg.sv =====
package tun_pkg;

  // input coordinate width
  localparam int COORD_WIDTH = 24;
  // edge vector component, difference of two coordinates
  localparam int EDGE_W = COORD_WIDTH + 1;
  // product of a pair of edge components
  localparam int PROD_W = 2 * EDGE_W;
  // cross product component before magnitude split
  localparam int CROSS_W = PROD_W + 1;
  // cross product magnitude
  localparam int MAG_W = PROD_W;
  // half magnitude for squaring by partial products
  localparam int HALF_W = MAG_W / 2;
  // squared length, sum of three squares
  localparam int SQ_W = 2 * MAG_W;
  // integer square root of the squared length
  localparam int ROOT_W = SQ_W / 2;
  // square root partial remainder
  localparam int REM_W = ROOT_W + 2;
  // quotient bits, Q1.30 magnitude
  localparam int Q_W = 31;
  localparam int OUT_W = 32;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int DIV_CELLS = Q_W;

  localparam logic [OUT_W-1:0] ONE_Q30 = OUT_W'(1) << (Q_W - 1);

  // side data carried along the square root chain
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  deg;
  } side_t;

  // side data carried along the divide chain
  typedef struct packed {
    logic [2:0] neg;
    logic       deg;
  } dside_t;

endpackage

// ===== hw/rtl/tun_sqrt_cell.sv =====
module tun_sqrt_cell
  import tun_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [SQ_W-1:0]   rad_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  side_t             side_i,
  output logic              vld_o,
  output logic [SQ_W-1:0]   rad_o,
  output logic [REM_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  logic              vld_r;
  logic [SQ_W-1:0]   rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  side_t             side_r;
  logic [REM_W+1:0]  cur;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  // one root bit: bring down two radicand bits, try 4*root+1
  always_comb begin
    cur      = {rem_i, rad_i[SQ_W-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    ge       = (cur >= trial);
    diff     = cur - trial;
    rem_nxt  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
    rad_nxt  = {rad_i[SQ_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

// ===== hw/rtl/tun_div_cell.sv =====
module tun_div_cell
  import tun_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic [ROOT_W-1:0]      len_i,
  input  logic [2:0][ROOT_W-1:0] r_i,
  input  logic [2:0]             lsb_i,
  input  logic [2:0][Q_W-1:0]    q_i,
  input  dside_t                 side_i,
  output logic                   vld_o,
  output logic [ROOT_W-1:0]      len_o,
  output logic [2:0][ROOT_W-1:0] r_o,
  output logic [2:0]             lsb_o,
  output logic [2:0][Q_W-1:0]    q_o,
  output dside_t                 side_o
);

  logic                   vld_r;
  logic [ROOT_W-1:0]      len_r;
  logic [2:0][ROOT_W-1:0] r_r, r_nxt;
  logic [2:0][Q_W-1:0]    q_r, q_nxt;
  dside_t                 side_r;
  logic [ROOT_W:0]        cur  [3];
  logic [ROOT_W:0]        diff [3];
  logic [2:0]             ge;

  // one quotient bit per lane, the three lanes share the divisor
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cur[k]   = {r_i[k], lsb_i[k]};
      ge[k]    = (cur[k] >= {1'b0, len_i});
      diff[k]  = cur[k] - {1'b0, len_i};
      r_nxt[k] = ge[k] ? diff[k][ROOT_W-1:0] : cur[k][ROOT_W-1:0];
      q_nxt[k] = {q_i[k][Q_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r  <= len_i;
      r_r    <= r_nxt;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign len_o  = len_r;
  assign r_o    = r_r;
  // the numerator has a single low bit, zeros follow it
  assign lsb_o  = 3'b000;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

// ===== hw/rtl/triangle_unit_normal_top.sv =====
// triangle unit normal, exact cross product normalized to signed q1.30
// pipeline: 7 front stages, 50 square root cells, 31 divide cells,
//   1 output register
// throughput: one triangle per cycle while out_ready does not stall the output, every stage is a pipeline register
// a stalled output beat freezes the whole pipeline until it is taken
// reset: synchronous active-low rst_n clears all valid bits, data is not reset
module triangle_unit_normal_top
  import tun_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_c_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       out_normal_x,
  output logic signed [OUT_W-1:0]       out_normal_y,
  output logic signed [OUT_W-1:0]       out_normal_z,
  output logic                          out_degenerate
);

  // output register valid bit
  logic out_valid_r;

  // pipeline advance: the output register is free or being emptied
  logic en;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage valid bits of the front end
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  // stage 1: edge vectors e0 = b - a, e1 = c - a
  logic signed [EDGE_W-1:0] e0_r [3];
  logic signed [EDGE_W-1:0] e1_r [3];
  // stage 2: the six cross products
  logic signed [PROD_W-1:0] p_r [3];
  logic signed [PROD_W-1:0] s_r [3];
  // stage 3: signed cross product components
  logic signed [CROSS_W-1:0] cr_r [3];
  // stage 4: sign and magnitude, zero test
  logic [2:0][MAG_W-1:0] mag4_r;
  logic [2:0]            neg4_r;
  logic                  deg4_r;
  // stage 5: partial products of each square
  logic [PROD_W-1:0] hh_r [3];
  logic [PROD_W-1:0] hl_r [3];
  logic [PROD_W-1:0] ll_r [3];
  side_t             sd5_r;
  // stage 6: the three squares
  logic [SQ_W-1:0] sq6_r [3];
  side_t           sd6_r;
  // stage 7: squared length
  logic [SQ_W-1:0] sum7_r;
  side_t           sd7_r;

  logic signed [CROSS_W-1:0] cr_nxt [3];
  logic [CROSS_W-1:0]        abs_c  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr_nxt[k] = CROSS_W'(p_r[k]) - CROSS_W'(s_r[k]);
      abs_c[k]  = cr_r[k][CROSS_W-1] ? CROSS_W'(-cr_r[k]) : CROSS_W'(cr_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // edges, one bit wider than a coordinate
      e0_r[0] <= EDGE_W'(in_b_x) - EDGE_W'(in_a_x);
      e0_r[1] <= EDGE_W'(in_b_y) - EDGE_W'(in_a_y);
      e0_r[2] <= EDGE_W'(in_b_z) - EDGE_W'(in_a_z);
      e1_r[0] <= EDGE_W'(in_c_x) - EDGE_W'(in_a_x);
      e1_r[1] <= EDGE_W'(in_c_y) - EDGE_W'(in_a_y);
      e1_r[2] <= EDGE_W'(in_c_z) - EDGE_W'(in_a_z);
      // n = e0 x e1 as p - s per component
      p_r[0] <= e0_r[1] * e1_r[2];
      s_r[0] <= e0_r[2] * e1_r[1];
      p_r[1] <= e0_r[2] * e1_r[0];
      s_r[1] <= e0_r[0] * e1_r[2];
      p_r[2] <= e0_r[0] * e1_r[1];
      s_r[2] <= e0_r[1] * e1_r[0];
      for (int k = 0; k < 3; k++) begin
        cr_r[k]   <= cr_nxt[k];
        mag4_r[k] <= abs_c[k][MAG_W-1:0];
        neg4_r[k] <= cr_r[k][CROSS_W-1];
      end
      // zero cross product means a zero-area triangle
      deg4_r <= (cr_r[0] == '0) && (cr_r[1] == '0) && (cr_r[2] == '0);
      // square of each magnitude from 25x25 partial products
      for (int k = 0; k < 3; k++) begin
        hh_r[k] <= mag4_r[k][MAG_W-1:HALF_W] * mag4_r[k][MAG_W-1:HALF_W];
        hl_r[k] <= mag4_r[k][MAG_W-1:HALF_W] * mag4_r[k][HALF_W-1:0];
        ll_r[k] <= mag4_r[k][HALF_W-1:0] * mag4_r[k][HALF_W-1:0];
      end
      sd5_r.mag <= mag4_r;
      sd5_r.neg <= neg4_r;
      sd5_r.deg <= deg4_r;
      for (int k = 0; k < 3; k++) begin
        sq6_r[k] <= (SQ_W'(hh_r[k]) << (2 * HALF_W))
                  + (SQ_W'(hl_r[k]) << (HALF_W + 1))
                  + SQ_W'(ll_r[k]);
      end
      sd6_r  <= sd5_r;
      sum7_r <= sq6_r[0] + sq6_r[1] + sq6_r[2];
      sd7_r  <= sd6_r;
    end
  end

  // square root chain, one root bit per cell
  logic              sq_vld  [SQRT_CELLS+1];
  logic [SQ_W-1:0]   sq_rad  [SQRT_CELLS+1];
  logic [REM_W-1:0]  sq_rem  [SQRT_CELLS+1];
  logic [ROOT_W-1:0] sq_root [SQRT_CELLS+1];
  side_t             sq_side [SQRT_CELLS+1];

  assign sq_vld[0]  = v7_r;
  assign sq_rad[0]  = sum7_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = sd7_r;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sq_vld[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_vld[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // divide chain, one quotient bit per cell for all three components
  // the remainder starts at mag/2 and the cells bring down mag[0], then zeros
  logic                   dv_vld  [DIV_CELLS+1];
  logic [ROOT_W-1:0]      dv_len  [DIV_CELLS+1];
  logic [2:0][ROOT_W-1:0] dv_r    [DIV_CELLS+1];
  logic [2:0]             dv_lsb  [DIV_CELLS+1];
  logic [2:0][Q_W-1:0]    dv_q    [DIV_CELLS+1];
  dside_t                 dv_side [DIV_CELLS+1];

  assign dv_vld[0]      = sq_vld[SQRT_CELLS];
  assign dv_len[0]      = sq_root[SQRT_CELLS];
  assign dv_q[0]        = '0;
  assign dv_side[0].neg = sq_side[SQRT_CELLS].neg;
  assign dv_side[0].deg = sq_side[SQRT_CELLS].deg;

  for (genvar k = 0; k < 3; k++) begin : g_dinit
    assign dv_r[0][k]   = ROOT_W'(sq_side[SQRT_CELLS].mag[k] >> 1);
    assign dv_lsb[0][k] = sq_side[SQRT_CELLS].mag[k][0];
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    tun_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (dv_vld[i]),
      .len_i  (dv_len[i]),
      .r_i    (dv_r[i]),
      .lsb_i  (dv_lsb[i]),
      .q_i    (dv_q[i]),
      .side_i (dv_side[i]),
      .vld_o  (dv_vld[i+1]),
      .len_o  (dv_len[i+1]),
      .r_o    (dv_r[i+1]),
      .lsb_o  (dv_lsb[i+1]),
      .q_o    (dv_q[i+1]),
      .side_o (dv_side[i+1])
    );
  end

  // output register: saturate, apply sign, fallback for degenerate beats
  logic [2:0][OUT_W-1:0] nrm_r, nrm_nxt;
  logic                 deg_r;
  logic [OUT_W-1:0]     qm [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qm[k] = OUT_W'(dv_q[DIV_CELLS][k]);
      if (qm[k] > ONE_Q30) begin
        qm[k] = ONE_Q30;
      end
      nrm_nxt[k] = dv_side[DIV_CELLS].neg[k] ? -qm[k] : qm[k];
    end
    if (dv_side[DIV_CELLS].deg) begin
      nrm_nxt[0] = '0;
      nrm_nxt[1] = '0;
      nrm_nxt[2] = ONE_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_r <= nrm_nxt;
      deg_r <= dv_side[DIV_CELLS].deg;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_degenerate = deg_r;

`ifndef SYNTH
  // a degenerate beat carries exactly the fallback normal
  a_deg_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == ONE_Q30)
    else $error("degenerate beat without fallback normal");

  // the normalized x component never exceeds one in magnitude
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_normal_x <= $signed(ONE_Q30) && out_normal_x >= -$signed(ONE_Q30))
    else $error("normal x out of range");

  // a proper triangle always has some nonzero component
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_normal_x != '0 || out_normal_y != '0 || out_normal_z != '0)
    else $error("zero normal on a non-degenerate beat");
`endif

endmodule
